// ===== rtl/pres_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and functions of the PRESENT-128 encryption pipeline.
// No dependencies; used by pres_round and present128_block_encrypt.
package pres_pkg;

   localparam int BLOCK_W   = 64;
   localparam int KEY_W     = 128;
   localparam int COUNTER_W = 5;
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_KEY_HIGH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW  = 1'd1;

   localparam logic [63:0] KEY_HIGH_RESET = 64'h0123_4567_89ab_cdef;
   localparam logic [63:0] KEY_LOW_RESET  = 64'h0123_4567_89ab_cdef;

   // S-box, entry n at SBOX[n].
   localparam logic [15:0][3:0] SBOX = {
      4'h2, 4'h1, 4'h7, 4'h4, 4'h8, 4'hf, 4'he, 4'h3,
      4'hd, 4'ha, 4'h0, 4'h9, 4'hb, 4'h6, 4'h5, 4'hc
   };

   // One beat travelling down the round pipeline.
   typedef struct packed {
      logic               valid;
      logic [BLOCK_W-1:0] state;
      logic [KEY_W-1:0]   key;
   } pres_stage_type;

   function automatic logic [BLOCK_W-1:0] sub_nibbles(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      y = '0;
      for (int n = 0; n < BLOCK_W / 4; n++) begin
         y[4*n +: 4] = SBOX[x[4*n +: 4]];
      end
      return y;
   endfunction

   // Bit i moves to bit 16*i mod 63; bit 63 stays in place.
   function automatic logic [BLOCK_W-1:0] permute_bits(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      y = '0;
      for (int b = 0; b < BLOCK_W - 1; b++) begin
         y[(16 * b) % 63] = x[b];
      end
      y[BLOCK_W-1] = x[BLOCK_W-1];
      return y;
   endfunction

   // Key register update: rotate left by 61, S-box on the top two nibbles,
   // round counter into bits 66..62.
   function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k,
                                                 input logic [COUNTER_W-1:0] counter);
      logic [KEY_W-1:0] r;
      r = {k[66:0], k[127:67]};
      r[127:124] = SBOX[r[127:124]];
      r[123:120] = SBOX[r[123:120]];
      r[66:62]   = r[66:62] ^ counter;
      return r;
   endfunction

endpackage

// ===== rtl/pres_round.sv =====
`timescale 1ns / 1ps
// One registered round of the PRESENT-128 pipeline: round key XOR, S-box layer,
// bit permutation and key update. Depends on pres_pkg.
module pres_round
   import pres_pkg::*;
#(
   parameter int ROUND_INDEX = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  pres_stage_type stage_in,
   output pres_stage_type stage_out
);

   logic               valid_ff;
   logic [BLOCK_W-1:0] state_ff;
   logic [BLOCK_W-1:0] state_in;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;

   always_comb begin
      state_in = permute_bits(sub_nibbles(stage_in.state ^ stage_in.key[KEY_W-1 -: BLOCK_W]));
      key_in   = next_key(stage_in.key, COUNTER_W'(ROUND_INDEX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      key_ff   <= key_in;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.state = state_ff;
   assign stage_out.key   = key_ff;

endmodule

// ===== rtl/present128_block_encrypt.sv =====
`timescale 1ns / 1ps
// PRESENT-128 block encryption, one round per pipeline stage plus a whitening register.
// Each beat passes through the round registers and then the result register.
// Throughput: one beat per cycle; busy is always low and the receiver cannot stall.
// Reset (synchronous, active high) empties the pipeline and loads the default key.
// Depends on pres_pkg and pres_round.
module present128_block_encrypt
   import pres_pkg::*;
#(
   parameter int ROUND_COUNT = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [BLOCK_W-1:0]   req_plaintext,
   output logic                 rsp_valid,
   output logic [BLOCK_W-1:0]   rsp_ciphertext,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   // The two key halves. The user must write configuration only while the pipeline is
   // empty, so every beat in flight sees the same key; the block does not enforce this.
   logic [63:0] key_high_ff;
   logic [63:0] key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= KEY_HIGH_RESET;
         key_low_ff  <= KEY_LOW_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_KEY_HIGH: key_high_ff <= csr_data;
            REG_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline never holds off a new beat: each stage moves every cycle.
   assign busy = 1'b0;

   // Stage 0 is the accepted beat itself, carrying the full key register so
   // that each round derives its own round key from the one before.
   pres_stage_type stage [ROUND_COUNT+1];

   assign stage[0].valid = start;
   assign stage[0].state = req_plaintext;
   assign stage[0].key   = {key_high_ff, key_low_ff};

   for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
      pres_round #(
         .ROUND_INDEX(r)
      ) u_round (
         .clock    (clock),
         .reset    (reset),
         .stage_in (stage[r-1]),
         .stage_out(stage[r])
      );
   end

   // Final whitening with the key left after the last update, then the
   // result register that drives the response strobe for one cycle.
   logic               rsp_valid_ff;
   logic [BLOCK_W-1:0] rsp_ciphertext_ff;
   logic [BLOCK_W-1:0] rsp_ciphertext_in;

   assign rsp_ciphertext_in = stage[ROUND_COUNT].state
                              ^ stage[ROUND_COUNT].key[KEY_W-1 -: BLOCK_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage[ROUND_COUNT].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ciphertext_ff <= rsp_ciphertext_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_ciphertext_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for present128_block_encrypt (PRESENT-128 pipeline).
// Depends on pres_pkg and the RTL of the block; holds its own cipher predictor.
module tb
   import pres_pkg::*;
();

   localparam int ROUND_COUNT    = 31;
   // One round per stage plus the whitening register.
   localparam int LATENCY        = ROUND_COUNT + 1;
   // Cycles without any accepted beat, result or key write before the run is abandoned.
   // The longest legal quiet stretch is the pipeline latency plus a short sender gap.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 6;
   localparam int BLOCKS_PER_PHASE = 325;
   localparam logic [63:0] ALL_ONES = '1;

   // Plaintexts for the first directed pass, run under the key loaded by reset.
   localparam int EDGE_COUNT = 7;
   localparam logic [63:0] EDGE_PLAINTEXTS [EDGE_COUNT] = '{
      64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef,
      64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h0000_0000_0000_0001,
      64'h8000_0000_0000_0000
   };
   // Plaintexts repeated under the all-zero and the all-one key.
   localparam int KEY_EDGE_COUNT = 4;
   localparam logic [63:0] KEY_EDGE_PLAINTEXTS [KEY_EDGE_COUNT] = '{
      64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
      64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000
   };

   // Predicts ciphertexts from the key it has seen written and matches them,
   // in order, against the beats the block returns.
   class cipher_scoreboard;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [63:0] ciphertext_q[$];
      int unsigned errors;

      function new();
         key_high = 64'h0123_4567_89ab_cdef;
         key_low  = 64'h0123_4567_89ab_cdef;
         errors   = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [63:0] data);
         if (index == REG_KEY_HIGH) begin
            key_high = data;
         end else if (index == REG_KEY_LOW) begin
            key_low = data;
         end
      endfunction

      function logic [3:0] sbox_lookup(logic [3:0] x);
         case (x)
            4'h0: return 4'hc;
            4'h1: return 4'h5;
            4'h2: return 4'h6;
            4'h3: return 4'hb;
            4'h4: return 4'h9;
            4'h5: return 4'h0;
            4'h6: return 4'ha;
            4'h7: return 4'hd;
            4'h8: return 4'h3;
            4'h9: return 4'he;
            4'ha: return 4'hf;
            4'hb: return 4'h8;
            4'hc: return 4'h4;
            4'hd: return 4'h7;
            4'he: return 4'h1;
            default: return 4'h2;
         endcase
      endfunction

      function logic [63:0] substitute_layer(logic [63:0] x);
         logic [63:0] y;
         for (int n = 0; n < 16; n++) begin
            y[4*n +: 4] = sbox_lookup(x[4*n +: 4]);
         end
         return y;
      endfunction

      function logic [63:0] spread_bits(logic [63:0] x);
         logic [63:0] y;
         for (int b = 0; b < 63; b++) begin
            y[(16 * b) % 63] = x[b];
         end
         y[63] = x[63];
         return y;
      endfunction

      function logic [127:0] advance_key_schedule(logic [127:0] k, logic [4:0] round);
         logic [127:0] r;
         r          = {k[66:0], k[127:67]};
         r[127:124] = sbox_lookup(r[127:124]);
         r[123:120] = sbox_lookup(r[123:120]);
         r[66:62]   = r[66:62] ^ round;
         return r;
      endfunction

      function logic [63:0] encrypt_block(logic [63:0] plaintext);
         logic [63:0]  state;
         logic [127:0] k;
         state = plaintext;
         k     = {key_high, key_low};
         for (int r = 1; r <= ROUND_COUNT; r++) begin
            state = spread_bits(substitute_layer(state ^ k[127:64]));
            k     = advance_key_schedule(k, r[4:0]);
         end
         return state ^ k[127:64];
      endfunction

      function void note_plaintext(logic [63:0] plaintext);
         ciphertext_q.push_back(encrypt_block(plaintext));
      endfunction

      function void check_ciphertext(logic [63:0] actual);
         logic [63:0] expected;
         if (ciphertext_q.size() == 0) begin
            $error("ciphertext: no result expected, actual %h", actual);
            errors++;
            return;
         end
         expected = ciphertext_q.pop_front();
         if (actual !== expected) begin
            $error("ciphertext: expected %h, actual %h", expected, actual);
            errors++;
         end
      endfunction

      function int pending();
         return ciphertext_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_plaintext;
   logic        rsp_valid;
   logic [63:0] rsp_ciphertext;
   logic        csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_data;

   cipher_scoreboard board;
   int unsigned quiet_cycles = 0;

   present128_block_encrypt #(
      .ROUND_COUNT(ROUND_COUNT)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_plaintext (req_plaintext),
      .rsp_valid     (rsp_valid),
      .rsp_ciphertext(rsp_ciphertext),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #10 clock = ~clock;

   // All sampling happens at the rising edge, where the values seen are the ones the
   // block itself registers, since every driver below updates through nonblocking
   // assignments. An input beat is noted before a result is checked, so the order
   // holds even for a pipeline with no delay at all.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_plaintext(req_plaintext);
         end
         if (rsp_valid) begin
            board.check_ciphertext(rsp_ciphertext);
         end
         if (csr_write_en) begin
            board.write_register(csr_index, csr_data);
         end
      end
   end

   // The watchdog restarts on any sign of progress. A lost result leaves the drain
   // loop waiting forever, and this is what ends such a run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Mostly dense random blocks; the rest are single set or cleared bits and
   // repeated nibbles, which push every S-box input through all sixteen lanes.
   function automatic logic [63:0] pick_plaintext();
      logic [63:0] one_hot;
      logic [3:0]  nibble;
      one_hot = 64'd1 << $urandom_range(63);
      nibble  = 4'($urandom_range(15));
      case ($urandom_range(9))
         0: return one_hot;
         1: return ~one_hot;
         2: return {16{nibble}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Both key halves go in on back-to-back edges while no beat is in flight.
   // Each task here is entered right after a rising edge.
   task automatic load_key(input logic [63:0] high, input logic [63:0] low);
      csr_write_en <= 1'b1;
      csr_index    <= REG_KEY_HIGH;
      csr_data     <= high;
      @(posedge clock);
      csr_index    <= REG_KEY_LOW;
      csr_data     <= low;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Offers one beat after a random number of idle cycles. When the next beat follows
   // at once, start simply stays high across the accepting edge.
   task automatic send_plaintext(input logic [63:0] plaintext, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_plaintext <= plaintext;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Every beat yields exactly one result, so an empty queue means the pipeline
   // is empty and the key may be changed safely.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic [63:0] key_high;
      logic [63:0] key_low;
      int          idle_pct;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_plaintext <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= REG_KEY_HIGH;
      csr_data      <= '0;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed pass under the reset key, then a second set of block extremes under the
      // all-zero and the all-one key.
      for (int i = 0; i < EDGE_COUNT; i++) begin
         send_plaintext(EDGE_PLAINTEXTS[i], 0);
      end
      drain();
      load_key('0, '0);
      for (int i = 0; i < KEY_EDGE_COUNT; i++) begin
         send_plaintext(KEY_EDGE_PLAINTEXTS[i], 26);
      end
      drain();
      load_key(ALL_ONES, ALL_ONES);
      for (int i = 0; i < KEY_EDGE_COUNT; i++) begin
         send_plaintext(KEY_EDGE_PLAINTEXTS[i], 47);
      end
      drain();

      // Random phases. The sender idles often, then very often, then never, so
      // gaps land on every stage of the pipeline and full-rate streams occur too.
      // Two phases mix an all-zero half with an all-one half of the key.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            1: begin
               key_high = '0;
               key_low  = ALL_ONES;
            end
            3: begin
               key_high = ALL_ONES;
               key_low  = '0;
            end
            default: begin
               key_high = {$urandom, $urandom};
               key_low  = {$urandom, $urandom};
            end
         endcase
         idle_pct = (phase < 2) ? 26 : (phase < 4) ? 47 : 0;
         load_key(key_high, key_low);
         repeat (BLOCKS_PER_PHASE) begin
            send_plaintext(pick_plaintext(), idle_pct);
         end
         drain();
      end

      // Give a stray extra result time to show up before the verdict.
      repeat (LATENCY + 4) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
